// ----- hw/rtl/svm_pkg.sv -----
// svm_pkg: sizes, request codes and item/command types for the voice mixer.
// No dependencies; imported by every module of the mixer.
package svm_pkg;

    localparam int VOICES      = 16;
    localparam int SOUNDS      = 8;
    localparam int FRAG_LEN    = 32;
    localparam int MAX_FRAGS   = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int SOUND_BYTES = MAX_FRAGS * FRAG_LEN;
    localparam int STORE_BYTES = SOUNDS * SOUND_BYTES;
    localparam int ADDR_W  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int SND_W   = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
    localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int K_W     = (FRAG_LEN > 1) ? $clog2(FRAG_LEN) : 1;
    localparam int LEN_W   = $clog2(MAX_FRAGS + 1);
    localparam int FRAG_W  = 7;
    localparam int SUM_W   = 10 + VOICE_W;
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_LEN   = 3'd1;
    localparam logic [2:0] REQ_TRIG  = 3'd2;
    localparam logic [2:0] REQ_QUIET = 3'd3;
    localparam logic [2:0] REQ_MIX   = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  sound_id;
        logic [10:0] byte_offset;
        logic [7:0]  raw_byte;
        logic [6:0]  length_frags;
    } svm_in_t;

    typedef struct packed {
        logic [7:0] mixed_sample;
        logic       last_of_fragment;
    } svm_out_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [SND_W-1:0]  sound;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [LEN_W-1:0]  len;
    } svm_cmd_t;

endpackage

// ----- hw/rtl/sample_voice_mixer.sv -----
// sample_voice_mixer: top level, multi-voice 8-bit PCM sample mixer.
// Depends on svm_pkg, svm_front, svm_queue, svm_back.
// A mix item frees finished voices, then for each sample walks all voices (one
// store read per voice) and registers the clipped sum; the back end pops no
// other item until the last sample of the fragment. Other items take effect
// as they are popped. Results cannot be stalled.
// Reset (rst_n, async low) frees all voices and empties all sound lengths;
// the sample store is not cleared.
module sample_voice_mixer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  svm_pkg::svm_in_t  req,
    output logic              result_valid,
    output svm_pkg::svm_out_t result
);
    import svm_pkg::*;

    // front: range checks, address and length formatting; invalid items dropped
    logic     push;
    svm_cmd_t push_cmd;
    // queue status / head
    logic     q_empty;
    logic     q_full;
    logic     pop;
    svm_cmd_t head;

    // busy only while the command queue is full
    assign busy = q_full;

    svm_front u_front (
        .start      (start),
        .queue_full (q_full),
        .req        (req),
        .push       (push),
        .cmd        (push_cmd)
    );

    svm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back: sample store, voice table and the per-voice mixing walk
    svm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (q_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );
endmodule

// ----- hw/rtl/svm_front.sv -----
// svm_front: checks and classifies items, builds commands for the queue.
// Depends on svm_pkg.
module svm_front (
    input  logic             start,
    input  logic             queue_full,
    input  svm_pkg::svm_in_t req,
    output logic             push,
    output svm_pkg::svm_cmd_t cmd
);
    import svm_pkg::*;

    logic id_ok;
    logic off_ok;
    logic keep;

    assign id_ok  = (5'(req.sound_id) < 5'(SOUNDS));
    assign off_ok = (16'(req.byte_offset) < 16'(SOUND_BYTES));

    always_comb
    begin
        unique case (req.req_type)
            REQ_LOAD:  keep = id_ok && off_ok;
            REQ_LEN:   keep = id_ok;
            REQ_TRIG:  keep = id_ok;
            REQ_QUIET: keep = 1'b1;
            REQ_MIX:   keep = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    assign push      = start && !queue_full && keep;
    assign cmd.op    = req.req_type;
    assign cmd.sound = SND_W'(req.sound_id);
    assign cmd.addr  = ADDR_W'(ADDR_W'(SND_W'(req.sound_id)) * ADDR_W'(SOUND_BYTES))
                     + ADDR_W'(req.byte_offset);
    // stored signed: offset binary with the top bit flipped
    assign cmd.data  = req.raw_byte ^ 8'h80;
    assign cmd.len   = (10'(req.length_frags) > 10'(MAX_FRAGS)) ? LEN_W'(MAX_FRAGS)
                                                                : LEN_W'(req.length_frags);
endmodule

// ----- hw/rtl/svm_queue.sv -----
// svm_queue: short command queue between front and back.
// Depends on svm_pkg.
module svm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  svm_pkg::svm_cmd_t push_cmd,
    input  logic              pop,
    output svm_pkg::svm_cmd_t head,
    output logic              empty,
    output logic              full
);
    import svm_pkg::*;

    svm_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("queue pop while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");
endmodule

// ----- hw/rtl/svm_back.sv -----
// svm_back: executes commands: sample store, sound lengths, voices, mixing.
// Depends on svm_pkg.
module svm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  svm_pkg::svm_cmd_t head,
    output logic              pop,
    output logic              result_valid,
    output svm_pkg::svm_out_t result
);
    import svm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FREE = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_TAIL = 2'd3;

    logic [7:0]         mem [STORE_BYTES];
    logic [7:0]         mem_q_reg;
    logic [VOICES-1:0]  voice_busy_reg;
    logic [SND_W-1:0]   voice_sound_reg [VOICES];
    logic [FRAG_W-1:0]  voice_frag_reg  [VOICES];
    logic [LEN_W-1:0]   sound_len_reg   [SOUNDS];
    logic [1:0]         state_reg;
    logic [VOICE_W-1:0] v_reg;
    logic [K_W-1:0]     k_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic               pend_reg;
    logic               valid_reg;
    svm_out_t           result_reg;

    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic               free_found;
    logic [VOICE_W-1:0] free_idx;
    logic signed [SUM_W-1:0] sample_ext;
    logic signed [SUM_W-1:0] sum_final;
    logic [7:0]         clipped;

    assign pop = (state_reg == ST_IDLE) && !empty;
    assign mem_we = pop && (head.op == REQ_LOAD);

    assign rd_addr = ADDR_W'(ADDR_W'(voice_sound_reg[v_reg]) * ADDR_W'(SOUND_BYTES))
                   + ADDR_W'(ADDR_W'(voice_frag_reg[v_reg]) * ADDR_W'(FRAG_LEN))
                   + ADDR_W'(k_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[head.addr] <= head.data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // lowest free voice
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!voice_busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = VOICE_W'(i);
            end
        end
    end

    assign sample_ext = pend_reg ? SUM_W'(signed'(mem_q_reg)) : '0;
    assign sum_final  = acc_reg + sample_ext;

    always_comb
    begin
        priority if (sum_final > SUM_W'(127))
            clipped = 8'h7F;
        else if (sum_final < -SUM_W'(128))
            clipped = 8'h80;
        else
            clipped = sum_final[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            voice_busy_reg <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                voice_sound_reg[i] <= '0;
                voice_frag_reg[i]  <= '0;
            end
            for (int j = 0; j < SOUNDS; j++)
            begin
                sound_len_reg[j] <= '0;
            end
            v_reg      <= '0;
            k_reg      <= '0;
            acc_reg    <= '0;
            pend_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        unique case (head.op)
                            REQ_LEN:   sound_len_reg[head.sound] <= head.len;
                            REQ_TRIG:
                            begin
                                if (free_found)
                                begin
                                    voice_busy_reg[free_idx]  <= 1'b1;
                                    voice_sound_reg[free_idx] <= head.sound;
                                    voice_frag_reg[free_idx]  <= '0;
                                end
                            end
                            REQ_QUIET: voice_busy_reg <= '0;
                            REQ_MIX:   state_reg <= ST_FREE;
                            default:   ;
                        endcase
                    end
                end
                ST_FREE:
                begin
                    for (int i = 0; i < VOICES; i++)
                    begin
                        if (10'(voice_frag_reg[i]) >= 10'(sound_len_reg[voice_sound_reg[i]]))
                        begin
                            voice_busy_reg[i] <= 1'b0;
                        end
                    end
                    v_reg     <= '0;
                    k_reg     <= '0;
                    acc_reg   <= '0;
                    pend_reg  <= 1'b0;
                    state_reg <= ST_WALK;
                end
                ST_WALK:
                begin
                    acc_reg  <= sum_final;
                    pend_reg <= voice_busy_reg[v_reg];
                    if (v_reg == VOICE_W'(VOICES - 1))
                    begin
                        state_reg <= ST_TAIL;
                    end
                    else
                    begin
                        v_reg <= v_reg + 1'b1;
                    end
                end
                ST_TAIL:
                begin
                    valid_reg                   <= 1'b1;
                    result_reg.mixed_sample     <= clipped ^ 8'h80;
                    result_reg.last_of_fragment <= (k_reg == K_W'(FRAG_LEN - 1));
                    acc_reg  <= '0;
                    pend_reg <= 1'b0;
                    v_reg    <= '0;
                    if (k_reg == K_W'(FRAG_LEN - 1))
                    begin
                        for (int i = 0; i < VOICES; i++)
                        begin
                            if (voice_busy_reg[i])
                            begin
                                voice_frag_reg[i] <= voice_frag_reg[i] + 1'b1;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_WALK;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    a_strobe_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $past(state_reg == ST_TAIL))
        else $error("result strobe without finished sample");
    a_last_ends_mix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_reg.last_of_fragment) |-> (state_reg == ST_IDLE))
        else $error("last sample did not end the mix");
    a_free_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FREE) |=> (state_reg == ST_WALK && v_reg == '0 && k_reg == '0))
        else $error("mix did not start at first voice and sample");
endmodule

// ----- verif/tb_sample_voice_mixer.sv -----
// tb_sample_voice_mixer: self-checking testbench for the voice mixer.
// Depends on svm_pkg and sample_voice_mixer; a directed table runs first, then random items.
`timescale 1ns / 1ps

module tb_sample_voice_mixer;
    import svm_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    svm_in_t  req;
    logic     result_valid;
    svm_out_t result;

    sample_voice_mixer dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .result_valid(result_valid), .result(result)
    );

    // Model state of the mixer
    logic             mdl_busy  [VOICES];
    logic [2:0]       mdl_sound [VOICES];
    logic [6:0]       mdl_frag  [VOICES];
    logic [6:0]       mdl_len   [SOUNDS];
    logic [7:0]       mdl_store [STORE_BYTES];

    svm_out_t sample_q[$];
    int       mismatches;
    int       send_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("FAIL sample_voice_mixer");
        $finish;
    end

    // Apply one accepted item to the model and queue the samples it causes.
    task automatic model_item(input svm_in_t it);
        int sum;
        int idx;
        begin
            case (it.req_type)
                REQ_LOAD:
                    if (it.sound_id < SOUNDS && it.byte_offset < SOUND_BYTES)
                    begin
                        idx = it.sound_id * SOUND_BYTES + it.byte_offset;
                        mdl_store[idx] = it.raw_byte ^ 8'h80;
                    end
                REQ_LEN:
                    if (it.sound_id < SOUNDS)
                        mdl_len[it.sound_id] = (it.length_frags > MAX_FRAGS) ?
                                               7'(MAX_FRAGS) : it.length_frags;
                REQ_TRIG:
                    if (it.sound_id < SOUNDS)
                    begin
                        for (int v = 0; v < VOICES; v++)
                            if (!mdl_busy[v])
                            begin
                                mdl_busy[v]  = 1'b1;
                                mdl_sound[v] = it.sound_id;
                                mdl_frag[v]  = '0;
                                break;
                            end
                    end
                REQ_QUIET:
                    for (int v = 0; v < VOICES; v++)
                        mdl_busy[v] = 1'b0;
                REQ_MIX:
                begin
                    // Voices that ran past their sound are freed first.
                    for (int v = 0; v < VOICES; v++)
                        if (mdl_busy[v] && mdl_frag[v] >= mdl_len[mdl_sound[v]])
                            mdl_busy[v] = 1'b0;
                    for (int k = 0; k < FRAG_LEN; k++)
                    begin
                        sum = 0;
                        for (int v = 0; v < VOICES; v++)
                            if (mdl_busy[v])
                            begin
                                idx = mdl_sound[v] * SOUND_BYTES + mdl_frag[v] * FRAG_LEN + k;
                                if (idx < STORE_BYTES)
                                    sum += $signed(mdl_store[idx]);
                            end
                        if (sum > 127)  sum = 127;
                        if (sum < -128) sum = -128;
                        sample_q.push_back('{mixed_sample: 8'(sum + 128),
                                             last_of_fragment: (k == FRAG_LEN - 1)});
                    end
                    for (int v = 0; v < VOICES; v++)
                        if (mdl_busy[v])
                            mdl_frag[v] = mdl_frag[v] + 7'd1;
                end
                default: ;
            endcase
        end
    endtask

    // Result checker: the receiver never stalls, so every strobe is taken.
    always @(posedge clk)
    begin
        svm_out_t exp_s;
        if (rst_n && result_valid)
        begin
            if (sample_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample %h/%b", result.mixed_sample,
                             result.last_of_fragment);
            end
            else
            begin
                exp_s = sample_q.pop_front();
                if (result !== exp_s)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample mismatch: exp %h/%b got %h/%b",
                                 exp_s.mixed_sample, exp_s.last_of_fragment,
                                 result.mixed_sample, result.last_of_fragment);
                end
            end
        end
    end

    // Drive one item and hold it until accepted, with random lead-in idling.
    // start stays high after acceptance; a lead-in idle of a later item or the end of the run drops it.
    task automatic send_item(input svm_in_t it);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start <= 1'b1;
            req   <= it;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            model_item(it);
        end
    endtask

    function automatic svm_in_t mk(input logic [2:0] t, input logic [2:0] id,
                                   input logic [10:0] off, input logic [7:0] b,
                                   input logic [6:0] len);
        mk = '{req_type: t, sound_id: id, byte_offset: off, raw_byte: b, length_frags: len};
    endfunction

    // Loads a full fragment of one sound with random or fixed bytes.
    task automatic load_frag(input logic [2:0] id, input int frag, input int fixed_b);
        for (int k = 0; k < FRAG_LEN; k++)
            send_item(mk(REQ_LOAD, id, 11'(frag * FRAG_LEN + k),
                         (fixed_b < 0) ? 8'($urandom) : 8'(fixed_b), 7'($urandom)));
    endtask

    // Loaded fragments per sound; random lengths are kept within this count.
    int loaded_frags [SOUNDS];

    // Directed table: rows with a known first sample carry it, others use the model.
    typedef struct {
        svm_in_t it;
        bit      has_exp;
        logic [7:0] first_exp;
    } dir_row_t;

    dir_row_t dir_tab[$];
    int       base;

    task automatic run_random(input int n);
        svm_in_t it;
        int      r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            it = mk(3'($urandom), 3'($urandom), 11'($urandom), 8'($urandom), 7'($urandom));
            if (r < 25)
                it.req_type = REQ_TRIG;
            else if (r < 55)
                it.req_type = REQ_MIX;
            else if (r < 65)
            begin
                // Lengths stay within what is loaded so no unwritten byte is read.
                it.req_type = REQ_LEN;
                it.length_frags = 7'($urandom_range(loaded_frags[it.sound_id]));
            end
            else if (r < 70)
                it.req_type = REQ_QUIET;
            else if (r < 78)
                it.req_type = 3'($urandom_range(5, 7));
            else if (r < 88)
            begin
                // Overwrite already-loaded bytes, or any offset of the sound.
                it.req_type = REQ_LOAD;
                if (loaded_frags[it.sound_id] > 0 && $urandom_range(1))
                    it.byte_offset = 11'($urandom_range(loaded_frags[it.sound_id]
                                                        * FRAG_LEN - 1));
            end
            else
                it.req_type = REQ_LOAD; // random offset, harmless: never played
            // A length over what is loaded could play unwritten bytes.
            if (it.req_type == REQ_LEN && it.length_frags > loaded_frags[it.sound_id])
                it.length_frags = 7'(loaded_frags[it.sound_id]);
            send_item(it);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        mismatches = 0;
        send_idle_pct = 37;
        for (int v = 0; v < VOICES; v++)
        begin
            mdl_busy[v] = 1'b0; mdl_sound[v] = '0; mdl_frag[v] = '0;
        end
        for (int s = 0; s < SOUNDS; s++)
        begin
            mdl_len[s] = '0; loaded_frags[s] = 0;
        end
        for (int a = 0; a < STORE_BYTES; a++)
        begin
            mdl_store[a] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: mix after reset is silence; full scale of one voice; clipping.
        dir_tab.push_back('{mk(REQ_MIX, 0, 0, 0, 0), 1, 8'd128});
        dir_tab.push_back('{mk(REQ_TRIG, 0, 0, 0, 0), 0, 0}); // zero length: freed
        dir_tab.push_back('{mk(REQ_MIX, 0, 0, 0, 0), 1, 8'd128});
        dir_tab.push_back('{mk(REQ_LEN, 1, 0, 0, 7'd127), 0, 0}); // saturates to max
        dir_tab.push_back('{mk(REQ_LEN, 1, 0, 0, 7'd1), 0, 0});
        dir_tab.push_back('{mk(REQ_LEN, 2, 0, 0, 7'd1), 0, 0});
        dir_tab.push_back('{mk(REQ_TRIG, 7, 0, 0, 0), 0, 0});
        dir_tab.push_back('{mk(REQ_TRIG, 1, 0, 0, 0), 0, 0});
        dir_tab.push_back('{mk(REQ_MIX, 0, 0, 0, 0), 1, 8'd255});
        dir_tab.push_back('{mk(REQ_TRIG, 2, 0, 0, 0), 0, 0});
        dir_tab.push_back('{mk(REQ_TRIG, 2, 0, 0, 0), 0, 0});
        dir_tab.push_back('{mk(REQ_MIX, 0, 0, 0, 0), 0, 0});
        dir_tab.push_back('{mk(REQ_MIX, 0, 0, 0, 0), 0, 0});
        dir_tab.push_back('{mk(3'd5, 0, 0, 0, 0), 0, 0});
        dir_tab.push_back('{mk(3'd7, 7, 11'h7FF, 8'hFF, 7'h7F), 0, 0});
        dir_tab.push_back('{mk(REQ_LOAD, 1, 11'h7FF, 8'h00, 0), 0, 0});
        dir_tab.push_back('{mk(REQ_QUIET, 0, 0, 0, 0), 0, 0});
        dir_tab.push_back('{mk(REQ_MIX, 0, 0, 0, 0), 1, 8'd128});

        // Sound 1: fragment 0 all 0xFF (+127); sound 2: fragment 0 all 0x00 (-128).
        load_frag(1, 0, 255);
        load_frag(2, 0, 0);
        loaded_frags[1] = 1; loaded_frags[2] = 1;

        foreach (dir_tab[i])
        begin
            base = sample_q.size();
            send_item(dir_tab[i].it);
            if (dir_tab[i].has_exp && sample_q.size() > base &&
                sample_q[base].mixed_sample !== dir_tab[i].first_exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: model gives %h, table %h", i,
                             sample_q[base].mixed_sample, dir_tab[i].first_exp);
            end
        end

        send_idle_pct = 37;
        run_random(14);
        send_idle_pct = 51;
        run_random(14);
        send_idle_pct = 0;
        run_random(14);
        start <= 1'b0;

        while (sample_q.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        if (mismatches == 0 && sample_q.size() == 0)
            $display("PASS sample_voice_mixer");
        else
            $display("FAIL sample_voice_mixer");
        $finish;
    end
endmodule
